FILE: sv/etfp_pkg.sv
// Shared types, constants and the byte-wide CRC-16 step for the ESC telemetry frame parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package etfp_pkg;

    localparam logic [7:0]  SYNC_BYTE     = 8'hA5;
    localparam logic [7:0]  TYPE_BYTE     = 8'h02;
    localparam logic [15:0] CRC_POLY      = 16'h1021;
    localparam logic [8:0]  TEMP_OFFSET   = 9'd40;

    localparam int          CNT_W         = 6;
    localparam logic [5:0]  FRAME_LEN     = 6'd34;
    localparam logic [5:0]  CRC_SPAN      = 6'd32;
    localparam logic [5:0]  CRC_LO_IDX    = 6'd32;
    localparam logic [5:0]  CRC_HI_IDX    = 6'd33;
    localparam logic [5:0]  SYNC_IDX      = 6'd0;
    localparam logic [5:0]  TYPE_IDX      = 6'd2;
    localparam logic [5:0]  PAYLOAD_FIRST = 6'd7;
    localparam logic [5:0]  PAYLOAD_LAST  = 6'd22;
    localparam logic [5:0]  COUNT_MAX     = 6'd63;
    localparam int          PAYLOAD_DEPTH = 16;

    localparam int          QUEUE_DEPTH_DEF = 2;
    localparam int          TDATA_W         = 136;

    // result status codes
    localparam logic [1:0]  STATUS_OK       = 2'd0;
    localparam logic [1:0]  STATUS_BAD_LEN  = 2'd1;
    localparam logic [1:0]  STATUS_BAD_HDR  = 2'd2;
    localparam logic [1:0]  STATUS_BAD_CRC  = 2'd3;

    typedef logic [7:0] byte_t;

    // one classified burst, handed from the front to the back
    typedef struct packed {
        logic [1:0]                    status;
        byte_t [PAYLOAD_DEPTH-1:0]     payload;  // frame bytes 7..22, entry 0 = byte 7
    } frame_rec_t;

    // CRC-16/XMODEM over one byte, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input byte_t b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: sv/etfp_front.sv
// Front end: takes received bytes, runs the CRC, checks header and length, captures payload.
// At each burst end it pushes one classified record into the queue. Uses etfp_pkg.
`default_nettype none

module etfp_front
    import etfp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       byte_valid,
    input  wire byte_t      byte_data,
    input  wire logic       byte_last,
    input  wire logic       queue_full,
    output logic            byte_ready,
    output logic            rec_push,
    output frame_rec_t      rec_data
);

    logic [CNT_W-1:0] cnt_reg, cnt_next, cnt_inc;
    logic [15:0]      crc_reg, crc_next;
    logic [15:0]      rcrc_reg, rcrc_next;
    logic             hdr_ok_reg, hdr_ok_next;
    byte_t [PAYLOAD_DEPTH-1:0] payload_reg, payload_next;
    logic             accept;
    logic             pay_wr;
    logic [3:0]       pay_off;
    logic [1:0]       status;
    logic [15:0]      crc_upd;
    logic [15:0]      rcrc_upd;
    logic [CNT_W-1:0] cnt_upd;
    logic             hdr_upd;

    assign byte_ready = !queue_full;
    assign accept     = byte_valid && byte_ready;

    always_comb begin
        crc_upd  = (cnt_reg < CRC_SPAN) ? crc_byte(crc_reg, byte_data) : crc_reg;
        hdr_upd  = hdr_ok_reg
                   && !((cnt_reg == SYNC_IDX) && (byte_data != SYNC_BYTE))
                   && !((cnt_reg == TYPE_IDX) && (byte_data != TYPE_BYTE));
        rcrc_upd = rcrc_reg;
        if (cnt_reg == CRC_LO_IDX) begin
            rcrc_upd = {rcrc_reg[15:8], byte_data};
        end else if (cnt_reg == CRC_HI_IDX) begin
            rcrc_upd = {byte_data, rcrc_reg[7:0]};
        end
        // saturate the count on overlong bursts
        cnt_inc  = (cnt_reg == COUNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
        cnt_upd  = cnt_inc;

        pay_wr   = (cnt_reg >= PAYLOAD_FIRST) && (cnt_reg <= PAYLOAD_LAST);
        pay_off  = 4'(cnt_reg - PAYLOAD_FIRST);
        payload_next = payload_reg;
        if (accept && pay_wr) begin
            payload_next[pay_off] = byte_data;
        end

        if (cnt_inc != FRAME_LEN) begin
            status = STATUS_BAD_LEN;
        end else if (!hdr_upd) begin
            status = STATUS_BAD_HDR;
        end else if (crc_upd != rcrc_upd) begin
            status = STATUS_BAD_CRC;
        end else begin
            status = STATUS_OK;
        end

        cnt_next    = cnt_reg;
        crc_next    = crc_reg;
        rcrc_next   = rcrc_reg;
        hdr_ok_next = hdr_ok_reg;
        if (accept) begin
            if (byte_last) begin
                // burst done: start over
                cnt_next    = '0;
                crc_next    = '0;
                rcrc_next   = '0;
                hdr_ok_next = 1'b1;
            end else begin
                cnt_next    = cnt_upd;
                crc_next    = crc_upd;
                rcrc_next   = rcrc_upd;
                hdr_ok_next = hdr_upd;
            end
        end
    end

    assign rec_push         = accept && byte_last;
    assign rec_data.status  = status;
    assign rec_data.payload = payload_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            crc_reg    <= '0;
            rcrc_reg   <= '0;
            hdr_ok_reg <= 1'b1;
        end else begin
            cnt_reg    <= cnt_next;
            crc_reg    <= crc_next;
            rcrc_reg   <= rcrc_next;
            hdr_ok_reg <= hdr_ok_next;
        end
    end

    always_ff @(posedge aclk) begin
        payload_reg <= payload_next;
    end

endmodule

`default_nettype wire

FILE: sv/etfp_queue.sv
// Short record queue between the front end and the result stage.
// Register-based, one push and one pop per cycle. Uses etfp_pkg.
`default_nettype none

module etfp_queue
    import etfp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push,
    input  wire frame_rec_t push_data,
    input  wire logic       pop,
    output frame_rec_t      pop_data,
    output logic            full,
    output logic            empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    frame_rec_t       entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_push, do_pop;

    assign full     = (fill_reg == CNT_W'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: sv/etfp_back.sv
// Result stage: pops classified records, extracts the telemetry fields, drives the output register.
// Uses etfp_pkg.
`default_nettype none

module etfp_back
    import etfp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire frame_rec_t  rec_data,
    input  wire logic        rec_empty,
    output logic             rec_pop,
    output logic             res_valid,
    input  wire logic        res_ready,
    output logic [TDATA_W-1:0] res_data,
    output logic [1:0]       res_status
);

    logic               valid_reg, valid_next;
    logic [TDATA_W-1:0] data_reg, data_next;
    logic [1:0]         status_reg, status_next;
    logic               take;

    function automatic logic [8:0] temp_of(input byte_t b);
        return {1'b0, b} - TEMP_OFFSET;
    endfunction

    // load a new result when the slot is empty or being drained
    assign take    = !rec_empty && (!valid_reg || res_ready);
    assign rec_pop = take;

    always_comb begin
        valid_next  = valid_reg;
        data_next   = data_reg;
        status_next = status_reg;
        if (take) begin
            valid_next  = 1'b1;
            status_next = rec_data.status;
            data_next   = '0;
            if (rec_data.status == STATUS_OK) begin
                data_next[8:0]     = temp_of(rec_data.payload[0]);
                data_next[24:9]    = {rec_data.payload[2],  rec_data.payload[1]};
                data_next[40:25]   = {rec_data.payload[4],  rec_data.payload[3]};
                data_next[56:41]   = {rec_data.payload[6],  rec_data.payload[5]};
                data_next[72:57]   = {rec_data.payload[8],  rec_data.payload[7]};
                data_next[80:73]   = rec_data.payload[9];
                data_next[88:81]   = rec_data.payload[10];
                data_next[104:89]  = {rec_data.payload[12], rec_data.payload[11]};
                data_next[120:105] = {rec_data.payload[14], rec_data.payload[13]};
                data_next[129:121] = temp_of(rec_data.payload[15]);
            end
        end else if (res_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg   <= data_next;
        status_reg <= status_next;
    end

    assign res_valid  = valid_reg;
    assign res_data   = data_reg;
    assign res_status = status_reg;

endmodule

`default_nettype wire

FILE: sv/esc_telemetry_frame_parser_top.sv
// A burst's record goes through the record queue and then the output register to m_tvalid.
// Throughput: one byte per cycle; s_tready drops only when the record queue is full,
// which happens only while the result output is stalled.
// Reset (aresetn low, synchronous) clears the byte counter, CRC, header flag, queue and
// output valid; captured payload bytes are not reset and are overwritten by each frame.
// Depends on etfp_pkg, etfp_front, etfp_queue and etfp_back.
`default_nettype none

module esc_telemetry_frame_parser_top
    import etfp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,   // [7:0] rx_byte
    input  wire logic               s_tlast,   // burst_end
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // [8:0] fet_temp, [24:9] batt_voltage, [40:25] motor_current, [56:41] consumed_mah,
    // [72:57] erpm_div10, [80:73] pwm_level, [88:81] throttle_level,
    // [104:89] bec_voltage_mv, [120:105] bec_current_ma, [129:121] bec_temp, rest zero
    output logic [TDATA_W-1:0]      m_tdata,
    output logic [1:0]              m_tuser    // [1:0] status
);

    logic       rec_push, rec_pop, q_full, q_empty;
    frame_rec_t push_rec, pop_rec;

    etfp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (s_tvalid),
        .byte_data  (s_tdata),
        .byte_last  (s_tlast),
        .queue_full (q_full),
        .byte_ready (s_tready),
        .rec_push   (rec_push),
        .rec_data   (push_rec)
    );

    etfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (rec_push),
        .push_data (push_rec),
        .pop       (rec_pop),
        .pop_data  (pop_rec),
        .full      (q_full),
        .empty     (q_empty)
    );

    etfp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rec_data   (pop_rec),
        .rec_empty  (q_empty),
        .rec_pop    (rec_pop),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res_data   (m_tdata),
        .res_status (m_tuser)
    );

endmodule

`default_nettype wire

FILE: sv/etfp_checker.sv
// Port-level checks for esc_telemetry_frame_parser_top, attached by the bind below.
// Uses etfp_pkg.
`default_nettype none

module etfp_checker
    import etfp_pkg::*;
(
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_tvalid,
    input wire logic               s_tready,
    input wire logic [7:0]         s_tdata,
    input wire logic               s_tlast,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [TDATA_W-1:0] m_tdata,
    input wire logic [1:0]         m_tuser
);

    // stalled result transfer holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // offered byte holds until it transfers
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tlast))
        else $error("input changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != STATUS_OK) |-> (m_tdata == '0))
        else $error("nonzero fields on a failed frame");

    a_temp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STATUS_OK)
        |-> ($signed(m_tdata[8:0]) >= -9'sd40) && ($signed(m_tdata[129:121]) >= -9'sd40)
            && (m_tdata[TDATA_W-1:130] == '0))
        else $error("temperature out of range or padding set");

endmodule

bind esc_telemetry_frame_parser_top etfp_checker u_etfp_checker (.*);

`default_nettype wire

FILE: bench/esc_telemetry_frame_parser_checker.sv
// Checker for the ESC telemetry frame parser: predicts one result per burst from the
// accepted bytes and compares each delivered result against the oldest prediction.
// Depends on etfp_pkg for the status codes and the result width.
`timescale 1ns / 100ps

module esc_telemetry_frame_parser_checker
    import etfp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [7:0]         s_tdata,    // [7:0] rx_byte
    input  logic               s_tlast,    // burst_end
    input  logic               m_tvalid,
    input  logic               m_tready,
    // [8:0] fet_temp .. [129:121] bec_temp, [135:130] zero
    input  logic [TDATA_W-1:0] m_tdata,
    input  logic [1:0]         m_tuser,    // [1:0] status
    output int                 fail_count,
    output int                 outstanding,
    output int                 results_seen,
    output int                 frames_good,
    output int                 input_stall_cycles
);

    localparam logic [7:0]  SYNC_VAL   = 8'hA5;
    localparam logic [7:0]  KIND_VAL   = 8'h02;
    localparam logic [15:0] POLY       = 16'h1021;
    localparam logic [8:0]  TEMP_BIAS  = 9'd40;
    localparam int          LEN_FRAME  = 34;
    localparam int          CRC_BYTES  = 32;
    localparam int          PL_FIRST   = 7;
    localparam int          PL_LAST    = 22;
    localparam int          CNT_SAT    = 63;
    localparam int          SYNC_POS   = 0;
    localparam int          KIND_POS   = 2;

    // same bit order as m_tdata, top member in the highest bits
    typedef struct packed {
        logic [5:0]  pad;
        logic [8:0]  bec_temp;
        logic [15:0] bec_current_ma;
        logic [15:0] bec_voltage_mv;
        logic [7:0]  throttle_level;
        logic [7:0]  pwm_level;
        logic [15:0] erpm_div10;
        logic [15:0] consumed_mah;
        logic [15:0] motor_current;
        logic [15:0] batt_voltage;
        logic [8:0]  fet_temp;
    } telemetry_t;

    typedef struct {
        logic [1:0] status;
        telemetry_t fields;
    } burst_verdict_t;

    burst_verdict_t expected_verdicts[$];

    logic [5:0]  rx_count;
    logic [15:0] crc_acc;
    logic        header_good;
    logic [7:0]  payload[16];
    logic [15:0] crc_received;

    function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] d);
        logic [15:0] c;
        logic        fb;
        c = acc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ d[i];
            c  = c << 1;
            if (fb) begin
                c = c ^ POLY;
            end
        end
        return c;
    endfunction

    task automatic report(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report($sformatf("result %0d field %s got %0d expected %0d",
                             results_seen, name, got, want));
        end
    endtask

    task automatic clear_burst();
        rx_count     = '0;
        crc_acc      = '0;
        header_good  = 1'b1;
        crc_received = '0;
    endtask

    // advance the frame state by one byte; at a burst end queue the verdict
    task automatic parse_byte(input logic [7:0] b, input logic burst_end);
        burst_verdict_t v;
        int             idx;
        idx = int'(rx_count);
        if (idx < CRC_BYTES) begin
            crc_acc = crc_step(crc_acc, b);
        end
        if (idx == SYNC_POS && b != SYNC_VAL) begin
            header_good = 1'b0;
        end
        if (idx == KIND_POS && b != KIND_VAL) begin
            header_good = 1'b0;
        end
        if (idx >= PL_FIRST && idx <= PL_LAST) begin
            payload[idx - PL_FIRST] = b;
        end
        if (idx == CRC_BYTES) begin
            crc_received[7:0] = b;
        end
        if (idx == CRC_BYTES + 1) begin
            crc_received[15:8] = b;
        end
        if (idx < CNT_SAT) begin
            rx_count = rx_count + 6'd1;
        end
        if (burst_end) begin
            v.fields = '0;
            if (rx_count != LEN_FRAME) begin
                v.status = STATUS_BAD_LEN;
            end else if (!header_good) begin
                v.status = STATUS_BAD_HDR;
            end else if (crc_acc != crc_received) begin
                v.status = STATUS_BAD_CRC;
            end else begin
                v.status = STATUS_OK;
            end
            if (v.status == STATUS_OK) begin
                v.fields.fet_temp       = {1'b0, payload[0]} - TEMP_BIAS;
                v.fields.batt_voltage   = {payload[2], payload[1]};
                v.fields.motor_current  = {payload[4], payload[3]};
                v.fields.consumed_mah   = {payload[6], payload[5]};
                v.fields.erpm_div10     = {payload[8], payload[7]};
                v.fields.pwm_level      = payload[9];
                v.fields.throttle_level = payload[10];
                v.fields.bec_voltage_mv = {payload[12], payload[11]};
                v.fields.bec_current_ma = {payload[14], payload[13]};
                v.fields.bec_temp       = {1'b0, payload[15]} - TEMP_BIAS;
            end
            expected_verdicts.push_back(v);
            clear_burst();
        end
    endtask

    task automatic check_result();
        burst_verdict_t want;
        telemetry_t     got;
        got = m_tdata;
        if (expected_verdicts.size() == 0) begin
            report($sformatf("result with status %0d arrived with no burst pending", m_tuser));
        end else begin
            want = expected_verdicts.pop_front();
            check_field("status", int'(m_tuser), int'(want.status));
            check_field("fet_temp", int'($signed(got.fet_temp)),
                        int'($signed(want.fields.fet_temp)));
            check_field("batt_voltage", int'(got.batt_voltage),
                        int'(want.fields.batt_voltage));
            check_field("motor_current", int'(got.motor_current),
                        int'(want.fields.motor_current));
            check_field("consumed_mah", int'(got.consumed_mah),
                        int'(want.fields.consumed_mah));
            check_field("erpm_div10", int'(got.erpm_div10), int'(want.fields.erpm_div10));
            check_field("pwm_level", int'(got.pwm_level), int'(want.fields.pwm_level));
            check_field("throttle_level", int'(got.throttle_level),
                        int'(want.fields.throttle_level));
            check_field("bec_voltage_mv", int'(got.bec_voltage_mv),
                        int'(want.fields.bec_voltage_mv));
            check_field("bec_current_ma", int'(got.bec_current_ma),
                        int'(want.fields.bec_current_ma));
            check_field("bec_temp", int'($signed(got.bec_temp)),
                        int'($signed(want.fields.bec_temp)));
            check_field("padding", int'(got.pad), int'(want.fields.pad));
            if (want.status == STATUS_OK) begin
                frames_good++;
            end
        end
        results_seen++;
    endtask

    initial begin
        fail_count         = 0;
        outstanding        = 0;
        results_seen       = 0;
        frames_good        = 0;
        input_stall_cycles = 0;
        clear_burst();
        foreach (payload[i]) begin
            payload[i] = '0;
        end
    end

    // sample pre-edge values; results of a byte never show up at its own edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_burst();
            expected_verdicts.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                check_result();
            end
            if (s_tvalid && s_tready) begin
                parse_byte(s_tdata, s_tlast);
            end
            if (s_tvalid && !s_tready) begin
                input_stall_cycles++;
            end
        end
        outstanding = expected_verdicts.size();
    end

endmodule

FILE: bench/esc_telemetry_frame_parser_top_tb.sv
// Stimulus and verdict for the ESC telemetry frame parser: directed bursts, a long
// output hold-off, then mostly well-formed random frames. Depends on etfp_pkg, the
// block's RTL and esc_telemetry_frame_parser_checker.
`timescale 1ns / 100ps

module esc_telemetry_frame_parser_top_tb;
    import etfp_pkg::*;

    localparam int  RESET_CYCLES   = 3;
    localparam int  HOLD_CYCLES    = 300;
    localparam int  RANDOM_BYTES   = 130;
    localparam int  MIN_BURSTS     = 4;
    localparam int  QUIET_BYTES    = 60;
    localparam int  QUIET_BURSTS   = 1;
    localparam int  DRAIN_CYCLES   = 10;
    localparam int  FRAME_BYTES    = 34;
    localparam int  CRC_BYTES      = 32;
    localparam int  MAX_BURST      = 70;

    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;   // [7:0] rx_byte
    logic               s_tlast;   // burst_end
    logic               m_tvalid;
    logic               m_tready;
    // [8:0] fet_temp .. [129:121] bec_temp, [135:130] zero
    logic [TDATA_W-1:0] m_tdata;
    logic [1:0]         m_tuser;   // [1:0] status

    int fail_count;
    int outstanding;
    int results_seen;
    int frames_good;
    int input_stall_cycles;

    bit quiet     = 1'b0;
    bit hold_req  = 1'b0;
    bit hold_done = 1'b0;
    int bytes_sent  = 0;
    int bursts_sent = 0;

    esc_telemetry_frame_parser_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    esc_telemetry_frame_parser_checker checker_i (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_tvalid           (s_tvalid),
        .s_tready           (s_tready),
        .s_tdata            (s_tdata),
        .s_tlast            (s_tlast),
        .m_tvalid           (m_tvalid),
        .m_tready           (m_tready),
        .m_tdata            (m_tdata),
        .m_tuser            (m_tuser),
        .fail_count         (fail_count),
        .outstanding        (outstanding),
        .results_seen       (results_seen),
        .frames_good        (frames_good),
        .input_stall_cycles (input_stall_cycles)
    );

    always #5 aclk = ~aclk;

    function automatic logic [15:0] frame_crc(input logic [15:0] acc, input logic [7:0] d);
        logic [15:0] c;
        logic        fb;
        c = acc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ d[i];
            c  = c << 1;
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    // offer one byte and hold it until the transfer happens
    task automatic push_byte(input logic [7:0] b, input bit burst_end, input int gap_pct);
        int gap;
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            s_tvalid = 1'b0;
            gap = $urandom_range(1, 19);
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = burst_end;
        do @(posedge aclk); while (s_tready !== 1'b1);
        @(negedge aclk);
        bytes_sent++;
    endtask

    // build a frame with a correct header and CRC, damage what is asked, send len bytes
    task automatic send_burst(input int len, input bit bad_sync, input bit bad_type,
                              input bit bad_crc, input fill_t fill);
        logic [7:0]  frame[$];
        logic [15:0] crc;
        int          gap_pct;
        int          span;
        span = (len > FRAME_BYTES) ? len : FRAME_BYTES;
        for (int i = 0; i < span; i++) begin
            case (fill)
                FILL_ZERO: frame.push_back(8'h00);
                FILL_ONES: frame.push_back(8'hFF);
                default:   frame.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        frame[0] = bad_sync ? (SYNC_BYTE ^ 8'($urandom_range(1, 255))) : SYNC_BYTE;
        frame[2] = bad_type ? (TYPE_BYTE ^ 8'($urandom_range(1, 255))) : TYPE_BYTE;
        crc = '0;
        for (int i = 0; i < CRC_BYTES; i++) begin
            crc = frame_crc(crc, frame[i]);
        end
        if (bad_crc) begin
            crc = crc ^ (16'h1 << $urandom_range(0, 15));
        end
        frame[CRC_BYTES]     = crc[7:0];
        frame[CRC_BYTES + 1] = crc[15:8];
        case ($urandom_range(0, 2))
            0:       gap_pct = 0;
            1:       gap_pct = 6;
            default: gap_pct = 25;
        endcase
        for (int i = 0; i < len; i++) begin
            push_byte(frame[i], i == len - 1, gap_pct);
        end
        bursts_sent++;
    endtask

    // result side: random stall bursts in stretches, one long hold-off on request
    initial begin : result_sink
        int stall_len;
        int stretch;
        int stall_pct;
        m_tready  = 1'b0;
        stretch   = 0;
        stall_pct = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (stretch == 0) begin
                stretch = 64;
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 10;
                    default: stall_pct = 35;
                endcase
            end
            stretch--;
            if (hold_req && !hold_done) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_done = 1'b1;
            end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
                m_tready  = 1'b0;
                stall_len = $urandom_range(1, 19);
                repeat (stall_len - 1) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    initial begin : stimulus
        int sel;
        int len;
        int rand_start;
        int rand_bursts;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // field extremes: all-zero payload gives -40 degrees, all-ones the maxima
        send_burst(FRAME_BYTES, 1'b0, 1'b0, 1'b0, FILL_ZERO);
        send_burst(FRAME_BYTES, 1'b0, 1'b0, 1'b0, FILL_ONES);
        send_burst(FRAME_BYTES, 1'b0, 1'b0, 1'b0, FILL_RANDOM);
        send_burst(FRAME_BYTES, 1'b0, 1'b0, 1'b1, FILL_RANDOM);
        send_burst(FRAME_BYTES, 1'b1, 1'b0, 1'b0, FILL_RANDOM);
        send_burst(FRAME_BYTES, 1'b0, 1'b1, 1'b0, FILL_RANDOM);
        // header fault outranks CRC fault, length outranks both
        send_burst(FRAME_BYTES, 1'b1, 1'b1, 1'b1, FILL_RANDOM);
        send_burst(FRAME_BYTES - 1, 1'b1, 1'b0, 1'b0, FILL_RANDOM);
        send_burst(1, 1'b0, 1'b0, 1'b0, FILL_RANDOM);
        send_burst(FRAME_BYTES - 1, 1'b0, 1'b0, 1'b0, FILL_RANDOM);
        send_burst(FRAME_BYTES + 1, 1'b0, 1'b0, 1'b0, FILL_RANDOM);
        // overlong bursts saturate the count; the next frame must start clean
        send_burst(63, 1'b0, 1'b0, 1'b0, FILL_RANDOM);
        send_burst(64, 1'b0, 1'b0, 1'b0, FILL_RANDOM);
        send_burst(MAX_BURST, 1'b0, 1'b0, 1'b0, FILL_ONES);
        send_burst(FRAME_BYTES, 1'b0, 1'b0, 1'b0, FILL_RANDOM);

        // hold the result side off while short bursts keep coming, to fill the block
        s_tvalid = 1'b0;
        @(posedge aclk);
        hold_req = 1'b1;
        @(negedge aclk);
        for (int i = 0; i < 16; i++) begin
            send_burst(1, 1'($urandom_range(0, 1)), 1'b0, 1'b0, FILL_RANDOM);
        end
        send_burst(FRAME_BYTES, 1'b0, 1'b0, 1'b0, FILL_RANDOM);

        rand_start  = bytes_sent;
        rand_bursts = 0;
        while (bytes_sent - rand_start < RANDOM_BYTES || rand_bursts < MIN_BURSTS) begin
            if (bytes_sent - rand_start >= QUIET_BYTES && rand_bursts >= QUIET_BURSTS) begin
                quiet = 1'b1;
            end
            sel = $urandom_range(0, 99);
            if (sel < 60) begin
                send_burst(FRAME_BYTES, 1'b0, 1'b0, 1'b0, FILL_RANDOM);
            end else if (sel < 68) begin
                send_burst(FRAME_BYTES, 1'b0, 1'b0, 1'b1, FILL_RANDOM);
            end else if (sel < 74) begin
                send_burst(FRAME_BYTES, 1'b1, 1'b0, 1'($urandom_range(0, 1)), FILL_RANDOM);
            end else if (sel < 80) begin
                send_burst(FRAME_BYTES, 1'b0, 1'b1, 1'($urandom_range(0, 1)), FILL_RANDOM);
            end else if (sel < 88) begin
                len = $urandom_range(2, MAX_BURST);
                if (len == FRAME_BYTES) begin
                    len = FRAME_BYTES + 1;
                end
                send_burst(len, 1'b0, 1'b0, 1'b0, FILL_RANDOM);
            end else begin
                // line noise: a few stray bytes
                send_burst($urandom_range(1, 6), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), 1'b0, FILL_RANDOM);
            end
            rand_bursts++;
        end
        s_tvalid = 1'b0;
        s_tlast  = 1'b0;

        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("sent %0d bytes in %0d bursts; checked %0d results, %0d of them good frames",
                 bytes_sent, bursts_sent, results_seen, frames_good);
        $display("input held back by the block for %0d cycles", input_stall_cycles);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("timeout with %0d results still expected", outstanding);
        $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: sim.f
sv/etfp_pkg.sv
sv/etfp_front.sv
sv/etfp_queue.sv
sv/etfp_back.sv
sv/esc_telemetry_frame_parser_top.sv
sv/etfp_checker.sv
bench/esc_telemetry_frame_parser_checker.sv
bench/esc_telemetry_frame_parser_top_tb.sv
